FILE: design/lfc_pkg.sv
// ----------------------------------------------------------------------------
// lfc_pkg
// shared types and constants of the six channel led fade controller
// ----------------------------------------------------------------------------
package lfc_pkg;

  localparam int NCH         = 6;
  localparam int LVL_W       = 10;
  localparam int LVL_MAX     = 1023;
  localparam int WHITE_CAP   = 500;
  localparam int STEP_W      = 6;
  localparam int ROW_W       = 5;
  localparam int CH_W        = 3;
  localparam int CMD_W       = 3;
  localparam int SCALE_W     = 9;
  localparam int SCALE_SHIFT = 8;
  localparam int SCALE_RESET = 256;
  localparam int FLOOR_RESET = 20;
  localparam int CFG_W       = 10;
  localparam int CFG_IDX_W   = 1;
  localparam int DQ_W        = 11;   // signed per-step quotient of a fade
  localparam int NUM_W       = 12;   // biased difference fed to the reciprocal multiply
  localparam int REC_SHIFT   = 20;   // reciprocal fraction bits
  localparam int REC_W       = 21;
  localparam int PROD_W      = NUM_W + REC_W;

  typedef logic [LVL_W-1:0] level_t;
  typedef level_t [NCH-1:0] levels_t;
  typedef logic signed [DQ_W-1:0] quot_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE       = 3'd0,
    CMD_RECIPE      = 3'd1,
    CMD_RECIPE_LOW  = 3'd2,
    CMD_MIN_COLD    = 3'd3,
    CMD_OFF         = 3'd4,
    CMD_FIXED_WHITE = 3'd5,
    CMD_RESERVE     = 3'd6,
    CMD_UNUSED      = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SETUP,
    S_STEP
  } state_t;

  typedef enum logic [1:0] {
    PH_READ,
    PH_TARGET,
    PH_DIV,
    PH_REM
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BATTERY_SCALE = 1'b0,
    CFG_COLD_FLOOR    = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic clear;
    logic advance;
  } step_ctrl_t;

endpackage

FILE: design/six_channel_led_fade_controller.sv
// ----------------------------------------------------------------------------
// six_channel_led_fade_controller
// recipe table of six channel led levels with linear crossfades
// ----------------------------------------------------------------------------
// a fade command gives its first word after setup, which takes every channel
//   through read, target, div and rem phases around the one shared multiplier
// throughput: a fade gives FADE_STEPS + 1 words, one per cycle while out_ready
//   is high; the next command is taken only once the final word is loaded
// a table write or an unused command code gives no word and starts no fade
// reset clears sequencer, output valid and current levels, and sets the config
//   registers to defaults; the recipe table is undefined until written
// ----------------------------------------------------------------------------
module six_channel_led_fade_controller import lfc_pkg::*; #(
  parameter int RECIPE_COUNT    = 32,
  parameter int FADE_STEPS      = 40,
  parameter int FIXED_WHITE_ROW = 28
) (
  input  logic                 clk,
  input  logic                 rst,
  // command channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CMD_W-1:0]     cmd,
  input  logic [ROW_W-1:0]     recipe_index,
  input  logic [CH_W-1:0]      channel_select,
  input  logic [LVL_W-1:0]     entry_value,
  // fade step channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [LVL_W-1:0]     warm_level,
  output logic [LVL_W-1:0]     cold_level,
  output logic [LVL_W-1:0]     red_level,
  output logic [LVL_W-1:0]     green_level,
  output logic [LVL_W-1:0]     blue_level,
  output logic [LVL_W-1:0]     sixth_level,
  output logic [STEP_W-1:0]    step_number,
  output logic                 final_step,
  // configuration writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // table is stored one level per ram word, row-major by channel
  localparam int DEPTH = RECIPE_COUNT * NCH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int AFW   = (AW > 8) ? AW : 8;
  localparam int REM_W = $clog2(FADE_STEPS) + 1;
  // bias keeps the difference positive; a whole multiple of the step count
  localparam int OFFK   = (LVL_MAX + FADE_STEPS - 1) / FADE_STEPS;
  localparam int OFFSET = OFFK * FADE_STEPS;
  // rounded-up reciprocal, exact floor for every biased difference
  localparam int RECIP  = (2 ** REC_SHIFT + FADE_STEPS - 1) / FADE_STEPS;

  state_t state, state_next;
  phase_t phase, phase_next;
  logic [CH_W-1:0] ch, ch_next;

  cmd_t             cmd_r;
  logic [ROW_W-1:0] row_r;
  logic [SCALE_W-1:0] battery_scale;
  level_t           cold_white_floor;

  levels_t          cur;
  levels_t          tgt;
  level_t           tgt_pre;
  level_t           tgt_pre_next;
  logic [NUM_W-1:0] n_r;
  quot_t            dq [NCH];
  logic [REM_W-1:0] dr [NCH];
  logic [STEP_W-1:0] step_cnt;

  levels_t          out_lv;
  levels_t          step_levels;

  logic             accept;
  logic             start;
  logic             load;
  logic             last_step;
  step_ctrl_t       step_ctrl;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [AW-1:0]    ram_raddr;
  level_t           ram_q;
  logic [ROW_W-1:0] row_sel;

  logic [NUM_W-1:0]  mul_a;
  logic [REC_W-1:0]  mul_b;
  logic [PROD_W-1:0] prod;

  logic [LVL_W:0]    scaled;
  level_t            target;
  level_t            raw;
  logic [NUM_W-1:0]  n_comb;
  logic [NUM_W-1:0]  qn;
  logic [NUM_W-1:0]  qd;
  logic [NUM_W-1:0]  qf;
  logic [NUM_W-1:0]  rem;

  function automatic logic row_ok(input logic [ROW_W-1:0] row);
    return (9'(row) < 9'(RECIPE_COUNT));
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [ROW_W-1:0] row,
                                            input logic [CH_W-1:0] c);
    logic [AFW-1:0] a;
    a = AFW'(row) * AFW'(NCH) + AFW'(c);
    return a[AW-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // handshake
  // ---------------------------------------------------------------------------
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  // every code from recipe to reserve white starts a fade
  assign start     = accept && (cmd != CMD_WRITE) && (cmd != CMD_UNUSED);
  // in the step run a new word goes into the output register when empty or taken
  assign load      = (state == S_STEP) && (!out_valid || out_ready);
  assign last_step = (step_cnt == STEP_W'(FADE_STEPS));

  assign step_ctrl.clear   = start;
  assign step_ctrl.advance = load && !last_step;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      battery_scale    <= SCALE_W'(SCALE_RESET);
      cold_white_floor <= LVL_W'(FLOOR_RESET);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_BATTERY_SCALE: battery_scale    <= cfg_data[SCALE_W-1:0];
        CFG_COLD_FLOOR:    cold_white_floor <= cfg_data[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // recipe table: written straight from the command word, read per channel
  // ---------------------------------------------------------------------------
  assign ram_we    = accept && (cmd == CMD_WRITE) &&
                     (channel_select < CH_W'(NCH)) && row_ok(recipe_index);
  assign ram_waddr = addr_of(recipe_index, channel_select);
  assign row_sel   = (cmd_r == CMD_FIXED_WHITE) ? ROW_W'(FIXED_WHITE_ROW) : row_r;
  assign ram_raddr = addr_of(row_sel, ch);

  lfc_ram #(
    .WIDTH (LVL_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (entry_value),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // ---------------------------------------------------------------------------
  // sequencer: four phases per channel, then the step run
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_READ;
      ch    <= '0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      ch    <= ch_next;
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    ch_next    = ch;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_SETUP;
          phase_next = PH_READ;
          ch_next    = '0;
        end
      end
      S_SETUP: begin
        case (phase)
          PH_READ:   phase_next = PH_TARGET;
          PH_TARGET: phase_next = PH_DIV;
          PH_DIV:    phase_next = PH_REM;
          PH_REM: begin
            phase_next = PH_READ;
            if (ch == CH_W'(NCH - 1)) begin
              state_next = S_STEP;
              ch_next    = '0;
            end else begin
              ch_next = ch + CH_W'(1);
            end
          end
          default: phase_next = PH_READ;
        endcase
      end
      S_STEP: begin
        if (load && last_step) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // setup datapath around the shared multiplier
  //   target phase: table level times battery scale
  //   div phase:    biased difference times reciprocal
  //   rem phase:    quotient and remainder of the per-step delta
  // ---------------------------------------------------------------------------
  assign raw    = row_ok(row_sel) ? ram_q : '0;
  assign scaled = prod[SCALE_SHIFT +: LVL_W+1];
  assign target = (cmd_r != CMD_RECIPE_LOW) ? tgt_pre :
                  (scaled > (LVL_W+1)'(LVL_MAX)) ? LVL_W'(LVL_MAX) :
                  scaled[LVL_W-1:0];
  assign n_comb = NUM_W'(target) - NUM_W'(cur[ch]) + NUM_W'(OFFSET);
  assign qn     = prod[REC_SHIFT +: NUM_W];
  assign qd     = qn - NUM_W'(OFFK);
  assign qf     = NUM_W'(qn * NUM_W'(FADE_STEPS));
  assign rem    = n_r - qf;

  always_comb begin
    case (cmd_r)
      CMD_RECIPE, CMD_RECIPE_LOW, CMD_FIXED_WHITE: tgt_pre_next = raw;
      CMD_MIN_COLD: tgt_pre_next = (ch == CH_W'(1)) ? cold_white_floor : '0;
      CMD_RESERVE:  tgt_pre_next = (ch < CH_W'(2)) ? cur[ch] : '0;
      default:      tgt_pre_next = '0;
    endcase
  end

  always_comb begin
    if (phase == PH_DIV) begin
      mul_a = n_comb;
      mul_b = REC_W'(RECIP);
    end else begin
      mul_a = NUM_W'(raw);
      mul_b = REC_W'(battery_scale);
    end
  end

  lfc_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_t'(cmd);
      row_r <= recipe_index;
    end
    if (state == S_SETUP) begin
      case (phase)
        PH_TARGET: tgt_pre <= tgt_pre_next;
        PH_DIV: begin
          tgt[ch] <= target;
          n_r     <= n_comb;
        end
        PH_REM: begin
          dq[ch] <= quot_t'(qd[DQ_W-1:0]);
          dr[ch] <= rem[REM_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // interpolation lanes
  // ---------------------------------------------------------------------------
  lfc_stepper #(
    .FADE_STEPS (FADE_STEPS)
  ) u_stepper (
    .clk         (clk),
    .ctrl        (step_ctrl),
    .dq          (dq),
    .dr          (dr),
    .old_levels  (cur),
    .step_levels (step_levels)
  );

  // ---------------------------------------------------------------------------
  // output register and current levels
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cur       <= '0;
      step_cnt  <= '0;
    end else begin
      if (start) begin
        step_cnt <= '0;
      end
      if (load) begin
        out_valid <= 1'b1;
        if (last_step) begin
          cur <= tgt;
        end else begin
          step_cnt <= step_cnt + STEP_W'(1);
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // the final word carries the exact target without clamping
  always_ff @(posedge clk) begin
    if (load) begin
      out_lv      <= last_step ? tgt : step_levels;
      step_number <= step_cnt;
      final_step  <= last_step;
    end
  end

  assign warm_level  = out_lv[0];
  assign cold_level  = out_lv[1];
  assign red_level   = out_lv[2];
  assign green_level = out_lv[3];
  assign blue_level  = out_lv[4];
  assign sixth_level = out_lv[5];

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_final_at_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && final_step |-> step_number == STEP_W'(FADE_STEPS))
    else $error("final word without last step number");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    step_cnt <= STEP_W'(FADE_STEPS))
    else $error("step counter past the final step");

  a_cur_stable: assert property (@(posedge clk) disable iff (rst)
    state != S_STEP |=> $stable(cur))
    else $error("current levels changed outside a step run");

  a_white_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid && !final_step |->
      warm_level <= LVL_W'(WHITE_CAP) && cold_level <= LVL_W'(WHITE_CAP))
    else $error("white level above cap on an interpolation word");

  a_ch_bound: assert property (@(posedge clk) disable iff (rst)
    ch < CH_W'(NCH))
    else $error("setup channel out of range");

endmodule

FILE: design/lfc_ram.sv
// ----------------------------------------------------------------------------
// lfc_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module lfc_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 192,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/lfc_mul.sv
// ----------------------------------------------------------------------------
// lfc_mul
// shared unsigned multiplier with registered product
// ----------------------------------------------------------------------------
module lfc_mul import lfc_pkg::*; (
  input  logic              clk,
  input  logic [NUM_W-1:0]  a,
  input  logic [REC_W-1:0]  b,
  output logic [PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

FILE: design/lfc_stepper.sv
// ----------------------------------------------------------------------------
// lfc_stepper
// six interpolation lanes, quotient and remainder accumulated each step
// ----------------------------------------------------------------------------
module lfc_stepper import lfc_pkg::*; #(
  parameter int FADE_STEPS = 40,
  localparam int REM_W = $clog2(FADE_STEPS) + 1
) (
  input  logic             clk,
  input  step_ctrl_t       ctrl,
  input  quot_t            dq [NCH],
  input  logic [REM_W-1:0] dr [NCH],
  input  levels_t          old_levels,
  output levels_t          step_levels
);

  quot_t                   q      [NCH];
  logic [REM_W-1:0]        r      [NCH];
  quot_t                   q_next [NCH];
  logic [REM_W-1:0]        r_next [NCH];
  logic [REM_W:0]          rsum   [NCH];
  logic signed [NUM_W-1:0] v      [NCH];

  // carry the remainder into the quotient once it reaches the step count
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      rsum[c] = {1'b0, r[c]} + {1'b0, dr[c]};
      if (rsum[c] >= (REM_W+1)'(FADE_STEPS)) begin
        r_next[c] = REM_W'(rsum[c] - (REM_W+1)'(FADE_STEPS));
        q_next[c] = q[c] + dq[c] + quot_t'(1);
      end else begin
        r_next[c] = REM_W'(rsum[c]);
        q_next[c] = q[c] + dq[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < NCH; c++) begin
      if (ctrl.clear) begin
        q[c] <= '0;
        r[c] <= '0;
      end else if (ctrl.advance) begin
        q[c] <= q_next[c];
        r[c] <= r_next[c];
      end
    end
  end

  // old level plus accumulated quotient, whites capped, floor at zero
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      v[c] = $signed({2'b00, old_levels[c]}) + NUM_W'(q[c]);
      if (c < 2 && v[c] > NUM_W'(WHITE_CAP)) begin
        step_levels[c] = LVL_W'(WHITE_CAP);
      end else if (v[c] < 0) begin
        step_levels[c] = '0;
      end else begin
        step_levels[c] = v[c][LVL_W-1:0];
      end
    end
  end

endmodule
